FILE: src/nv12cb_pkg.sv
// Shared constants, types and the bar color table for the NV12 color bar generator.
package nv12cb_pkg;

	// field widths
	localparam int FRAME_W  = 32;
	localparam int COL_W    = 12;
	localparam int POS_W    = COL_W + 1;
	localparam int CFG_W    = 13;
	localparam int SAMPLE_W = 8;
	localparam int BAR_W    = 3;

	// width register limits and reset value
	localparam int DEF_MAX_WIDTH = 4096;
	localparam int MIN_WIDTH     = 8;
	localparam int RESET_WIDTH   = 1920;

	// scroll step is four pixels per frame, applied as a left shift
	localparam int SCROLL_SHIFT = 2;

	// remainder pipeline: dividend bits handled per stage
	localparam int STEPS_PER_STAGE = 4;
	localparam int DIV_STAGES      = FRAME_W / STEPS_PER_STAGE;

	typedef struct packed {
		logic [SAMPLE_W-1:0] y;
		logic [SAMPLE_W-1:0] u;
		logic [SAMPLE_W-1:0] v;
	} color_t;

	// white, yellow, cyan, green, magenta, red, blue, black
	function automatic color_t bar_color(logic [BAR_W-1:0] bar);
		color_t c;
		case (bar)
			3'd0:    c = '{y: 8'd235, u: 8'd128, v: 8'd128};
			3'd1:    c = '{y: 8'd210, u: 8'd16,  v: 8'd146};
			3'd2:    c = '{y: 8'd170, u: 8'd166, v: 8'd16};
			3'd3:    c = '{y: 8'd145, u: 8'd54,  v: 8'd34};
			3'd4:    c = '{y: 8'd107, u: 8'd202, v: 8'd222};
			3'd5:    c = '{y: 8'd82,  u: 8'd90,  v: 8'd240};
			3'd6:    c = '{y: 8'd41,  u: 8'd240, v: 8'd110};
			default: c = '{y: 8'd16,  u: 8'd128, v: 8'd128};
		endcase
		return c;
	endfunction

endpackage

FILE: src/nv12cb_div_pipe.sv
// Pipelined restoring remainder unit: shift mod W and position mod W in two lanes.
module nv12cb_div_pipe #(
	parameter int WW = 13
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic [WW-1:0]                w,
	input  logic                         in_valid,
	input  logic [nv12cb_pkg::FRAME_W-1:0] in_x,
	input  logic [nv12cb_pkg::POS_W-1:0] in_pos,
	input  logic                         in_plane,
	output logic                         out_valid,
	output logic [WW-1:0]                out_rx,
	output logic [WW-1:0]                out_rp,
	output logic                         out_plane
);

	localparam int XW  = nv12cb_pkg::FRAME_W;
	localparam int NST = nv12cb_pkg::DIV_STAGES;
	localparam int SPS = nv12cb_pkg::STEPS_PER_STAGE;

	// one restoring step: bring in the next dividend bit, subtract W if it fits
	function automatic logic [WW-1:0] mod_step(logic [WW-1:0] r, logic b, logic [WW-1:0] d);
		logic [WW:0] t;
		t = {r, b};
		if (t >= {1'b0, d})
			t = t - {1'b0, d};
		return t[WW-1:0];
	endfunction

	// stage registers, index is the stage within this unit
	logic                v_s     [NST];
	logic [XW-1:0]       x_s     [NST];
	logic [XW-1:0]       pos_s   [NST];
	logic [WW-1:0]       rx_s    [NST];
	logic [WW-1:0]       rp_s    [NST];
	logic                plane_s [NST];

	for (genvar s = 0; s < NST; s++) begin : g_stg
		logic          src_v;
		logic [XW-1:0] src_x;
		logic [XW-1:0] src_pos;
		logic [WW-1:0] src_rx;
		logic [WW-1:0] src_rp;
		logic          src_plane;
		logic [WW-1:0] nx_rx;
		logic [WW-1:0] nx_rp;

		if (s == 0) begin : g_first
			assign src_v     = in_valid;
			assign src_x     = in_x;
			assign src_pos   = XW'(in_pos);
			assign src_rx    = '0;
			assign src_rp    = '0;
			assign src_plane = in_plane;
		end else begin : g_next
			assign src_v     = v_s[s-1];
			assign src_x     = x_s[s-1];
			assign src_pos   = pos_s[s-1];
			assign src_rx    = rx_s[s-1];
			assign src_rp    = rp_s[s-1];
			assign src_plane = plane_s[s-1];
		end

		// this stage's share of dividend bits, MSB first
		always_comb begin
			nx_rx = src_rx;
			nx_rp = src_rp;
			for (int k = 0; k < SPS; k++) begin
				nx_rx = mod_step(nx_rx, src_x[XW-1-(s*SPS+k)], w);
				nx_rp = mod_step(nx_rp, src_pos[XW-1-(s*SPS+k)], w);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[s] <= 1'b0;
			end else if (en) begin
				v_s[s] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[s]     <= src_x;
				pos_s[s]   <= src_pos;
				rx_s[s]    <= nx_rx;
				rp_s[s]    <= nx_rp;
				plane_s[s] <= src_plane;
			end
		end
	end

	assign out_valid = v_s[NST-1];
	assign out_rx    = rx_s[NST-1];
	assign out_rp    = rp_s[NST-1];
	assign out_plane = plane_s[NST-1];

endmodule

FILE: src/nv12_color_bar_generator_core.sv
// Top level of the NV12 color bar generator: input stage, remainder pipeline, bar select.
// Throughput: one word per cycle while the output is not stalled.
// The 32-bit remainder pipeline (4 bits per stage) sets depth.
// A stall at the output holds every stage in place; nothing is dropped or repeated.
// Reset clears all stage valid bits and sets the width register to 1920 (clamped).
// Width writes are taken in any cycle (cfg_ready is always high).
module nv12_color_bar_generator_core #(
	parameter int MAX_WIDTH = nv12cb_pkg::DEF_MAX_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [nv12cb_pkg::CFG_W-1:0]      cfg_data,
	// input words
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [nv12cb_pkg::FRAME_W-1:0]    frame_number,
	input  logic [nv12cb_pkg::COL_W-1:0]      column,
	input  logic                              plane,
	// result words
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [nv12cb_pkg::SAMPLE_W-1:0]   sample_first,
	output logic [nv12cb_pkg::SAMPLE_W-1:0]   sample_second,
	output logic [nv12cb_pkg::BAR_W-1:0]      bar_number
);

	localparam int WW      = $clog2(MAX_WIDTH + 1);
	localparam int RST_EFF = (nv12cb_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
	                                                              : nv12cb_pkg::RESET_WIDTH;
	localparam int XW      = nv12cb_pkg::FRAME_W;
	localparam int PW      = nv12cb_pkg::POS_W;
	localparam int BW      = nv12cb_pkg::BAR_W;

	logic          en;
	logic [WW-1:0] w_q;

	// effective width, clamped at write time
	logic [31:0]   cfg_ext;
	logic [WW-1:0] cfg_eff;

	assign cfg_ready = 1'b1;
	assign cfg_ext   = 32'(cfg_data);

	always_comb begin
		if (cfg_ext < 32'(nv12cb_pkg::MIN_WIDTH))
			cfg_eff = WW'(nv12cb_pkg::MIN_WIDTH);
		else if (cfg_ext > 32'(MAX_WIDTH))
			cfg_eff = WW'(MAX_WIDTH);
		else
			cfg_eff = WW'(cfg_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= WW'(RST_EFF);
		end else if (cfg_valid && cfg_ready) begin
			w_q <= cfg_eff;
		end
	end

	// global advance: the whole pipe moves unless the output word is stuck
	logic v_s11;
	assign en       = !v_s11 || out_ready;
	assign in_ready = en;

	// stage 1: capture, scale frame by the scroll step, form position
	logic          v_s1;
	logic [XW-1:0] x_s1;
	logic [PW-1:0] pos_s1;
	logic          plane_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1     <= {frame_number[XW-1-nv12cb_pkg::SCROLL_SHIFT:0],
			             {nv12cb_pkg::SCROLL_SHIFT{1'b0}}};
			pos_s1   <= plane ? {column, 1'b0} : {1'b0, column};
			plane_s1 <= plane;
		end
	end

	// stages 2 to 9: shift mod W and position mod W
	logic          v_s9;
	logic [WW-1:0] rx_s9;
	logic [WW-1:0] rp_s9;
	logic          plane_s9;

	nv12cb_div_pipe #(
		.WW (WW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.w         (w_q),
		.in_valid  (v_s1),
		.in_x      (x_s1),
		.in_pos    (pos_s1),
		.in_plane  (plane_s1),
		.out_valid (v_s9),
		.out_rx    (rx_s9),
		.out_rp    (rp_s9),
		.out_plane (plane_s9)
	);

	// stage 10: (pos + shift) mod W, both parts already below W
	logic          v_s10;
	logic [WW-1:0] r_s10;
	logic          plane_s10;
	logic [WW:0]   sum;
	logic [WW:0]   sum_red;

	always_comb begin
		sum     = {1'b0, rx_s9} + {1'b0, rp_s9};
		sum_red = sum;
		if (sum >= {1'b0, w_q})
			sum_red = sum - {1'b0, w_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s10     <= sum_red[WW-1:0];
			plane_s10 <= plane_s9;
		end
	end

	// stage 11: bar = floor(8 * r / W), three quotient bits, then color lookup
	logic [BW-1:0]     bar;
	logic [WW-1:0]     br;
	logic [WW:0]       bt;
	nv12cb_pkg::color_t col;

	always_comb begin
		br  = r_s10;
		bar = '0;
		for (int k = 0; k < BW; k++) begin
			bt = {br, 1'b0};
			if (bt >= {1'b0, w_q}) begin
				bt          = bt - {1'b0, w_q};
				bar[BW-1-k] = 1'b1;
			end
			br = bt[WW-1:0];
		end
		col = nv12cb_pkg::bar_color(bar);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (en) begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sample_first  <= plane_s10 ? col.u : col.y;
			sample_second <= plane_s10 ? col.v : '0;
			bar_number    <= bar;
		end
	end

	assign out_valid = v_s11;

endmodule

FILE: verif/nv12cb_sample_checker.sv
// Sample checker for the NV12 color bar generator: predicts each result word and compares it.
module nv12cb_sample_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [nv12cb_pkg::CFG_W-1:0]    cfg_data,
	input  logic                            in_valid,
	input  logic                            in_ready,
	input  logic [nv12cb_pkg::FRAME_W-1:0]  frame_number,
	input  logic [nv12cb_pkg::COL_W-1:0]    column,
	input  logic                            plane,
	input  logic                            out_valid,
	input  logic                            out_ready,
	input  logic [nv12cb_pkg::SAMPLE_W-1:0] sample_first,
	input  logic [nv12cb_pkg::SAMPLE_W-1:0] sample_second,
	input  logic [nv12cb_pkg::BAR_W-1:0]    bar_number,
	output int                              mismatch_count,
	output int                              samples_owed
);

	localparam int REPORT_LIMIT = 10;
	localparam int SW = nv12cb_pkg::SAMPLE_W;
	localparam int BW = nv12cb_pkg::BAR_W;
	localparam int FW = nv12cb_pkg::FRAME_W;
	localparam int CW = nv12cb_pkg::COL_W;
	localparam int GW = nv12cb_pkg::CFG_W;

	typedef struct packed {
		logic [SW-1:0] first;
		logic [SW-1:0] second;
		logic [BW-1:0] bar;
	} bar_sample_t;

	// bar levels, white through black
	localparam logic [SW-1:0] LUMA_LEVEL [8] = '{
		8'd235, 8'd210, 8'd170, 8'd145, 8'd107, 8'd82, 8'd41, 8'd16};
	localparam logic [SW-1:0] CB_LEVEL [8] = '{
		8'd128, 8'd16, 8'd166, 8'd54, 8'd202, 8'd90, 8'd240, 8'd128};
	localparam logic [SW-1:0] CR_LEVEL [8] = '{
		8'd128, 8'd146, 8'd16, 8'd34, 8'd222, 8'd240, 8'd110, 8'd128};

	logic [GW-1:0] width_shadow;
	bar_sample_t   owed_samples [$];
	bar_sample_t   want, got;
	int            results_seen;

	// sample at one column of one frame, for the given width setting
	function automatic bar_sample_t color_bar_at(logic [FW-1:0] frame,
			logic [CW-1:0] col, logic chroma, logic [GW-1:0] width_set);
		longint unsigned divisor, scroll, offset, position;
		logic [FW-1:0] advance;
		logic [BW-1:0] sel;
		bar_sample_t s;
		divisor = width_set;
		if (divisor < nv12cb_pkg::MIN_WIDTH) divisor = nv12cb_pkg::MIN_WIDTH;
		if (divisor > nv12cb_pkg::DEF_MAX_WIDTH) divisor = nv12cb_pkg::DEF_MAX_WIDTH;
		// four pixels per frame, wrapped to 32 bits
		advance = {frame[FW-3:0], 2'b00};
		scroll = advance;
		offset = scroll % divisor;
		// chroma pairs sit at twice their index
		position = col;
		if (chroma) position = position * 2;
		sel = BW'(((position + offset) * 8 / divisor) % 8);
		s.bar = sel;
		if (chroma) begin
			s.first  = CB_LEVEL[sel];
			s.second = CR_LEVEL[sel];
		end else begin
			s.first  = LUMA_LEVEL[sel];
			s.second = '0;
		end
		return s;
	endfunction

	initial begin
		mismatch_count = 0;
		results_seen = 0;
	end

	// track width writes, queue predictions, compare result words in order
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_shadow <= GW'(nv12cb_pkg::RESET_WIDTH);
			owed_samples.delete();
			samples_owed <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				width_shadow <= cfg_data;
			if (out_valid && out_ready) begin
				got = '{first: sample_first, second: sample_second, bar: bar_number};
				if (owed_samples.size() == 0) begin
					if (mismatch_count < REPORT_LIMIT)
						$display("result word %0d with none owed: first=%0d second=%0d bar=%0d",
							results_seen, got.first, got.second, got.bar);
					mismatch_count++;
				end else begin
					want = owed_samples.pop_front();
					if (got.first !== want.first || got.second !== want.second ||
							got.bar !== want.bar) begin
						if (mismatch_count < REPORT_LIMIT)
							$display("result word %0d: expected first=%0d second=%0d bar=%0d, %s%0d %0d %0d",
								results_seen, want.first, want.second, want.bar, "got ",
								got.first, got.second, got.bar);
						mismatch_count++;
					end
				end
				results_seen++;
			end
			if (in_valid && in_ready)
				owed_samples.push_back(color_bar_at(frame_number, column, plane, width_shadow));
			samples_owed <= owed_samples.size();
		end
	end

endmodule

FILE: verif/tb_top.sv
// Testbench top for the NV12 color bar generator: stimulus, width settings and verdict.
module tb_top;

	localparam int FW = nv12cb_pkg::FRAME_W;
	localparam int CW = nv12cb_pkg::COL_W;
	localparam int GW = nv12cb_pkg::CFG_W;

	localparam int PIPE_PAD     = 16;    // covers the pipeline
	localparam int TAIL_CYCLES  = 24;
	localparam int QUIET_LIMIT  = 4000;
	localparam int PHASE_WORDS  = 100;
	localparam int HOLD_AT      = 450;
	localparam int HOLD_CYCLES  = 300;
	localparam int CALM_FROM    = 650;
	localparam int CALM_TO      = 850;
	localparam logic [GW-1:0] WIDTH_PLAN [8] = '{
		13'd8191, 13'd0, 13'd4096, 13'd7, 13'd8, 13'd1000, 13'd4097, 13'd1920};

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [GW-1:0]                   cfg_data;
	logic                            in_valid;
	logic                            in_ready;
	logic [FW-1:0]                   frame_number;
	logic [CW-1:0]                   column;
	logic                            plane;
	logic                            out_valid;
	logic                            out_ready;
	logic [nv12cb_pkg::SAMPLE_W-1:0] sample_first;
	logic [nv12cb_pkg::SAMPLE_W-1:0] sample_second;
	logic [nv12cb_pkg::BAR_W-1:0]    bar_number;
	int                              mismatch_count;
	int                              samples_owed;
	int                              words_sent = 0;
	int                              quiet_cycles = 0;
	logic                            hold_done = 1'b0;

	wire steady_run = (words_sent >= CALM_FROM) && (words_sent < CALM_TO);

	always #4 clk = ~clk;

	nv12_color_bar_generator_core u_top (.*);

	nv12cb_sample_checker u_checker (.*);

	// offer one word, after a random idle gap outside the calm stretch, and wait until it is taken
	task automatic push_word(input logic [FW-1:0] f, input logic [CW-1:0] c,
			input logic p);
		int gap;
		gap = 0;
		if (!steady_run)
			while ($urandom_range(99) < 23) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		frame_number <= f;
		column       <= c;
		plane        <= p;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	// stop sending and wait for every owed result word
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (samples_owed != 0);
	endtask

	// width write only while the pipeline is empty
	task automatic write_width(input logic [GW-1:0] w);
		drain_results();
		repeat (PIPE_PAD) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= w;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// mostly scan runs of consecutive columns, the rest scattered words
	task automatic random_words(input int count);
		int left, run;
		logic [FW-1:0] f;
		logic [CW-1:0] c;
		logic p;
		left = count;
		while (left > 0) begin
			f = ($urandom_range(3) == 0) ? FW'($urandom_range(1023)) : $urandom;
			p = 1'($urandom_range(1));
			c = CW'($urandom_range(4095));
			run = ($urandom_range(99) < 70) ? $urandom_range(4, 32) : 1;
			if (run > left) run = left;
			repeat (run) begin
				push_word(f, c, p);
				c = c + CW'(1);
				left--;
			end
		end
	endtask

	// receiver: random stalls, one long hold-off, and a calm stretch
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && words_sent >= HOLD_AT) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(posedge clk);
				hold_done = 1'b1;
			end else begin
				out_ready <= steady_run || ($urandom_range(99) >= 23);
			end
		end
	end

	// cycles with no word moving on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		arst_n       <= 1'b0;
		cfg_valid    <= 1'b0;
		cfg_data     <= '0;
		in_valid     <= 1'b0;
		frame_number <= '0;
		column       <= '0;
		plane        <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset width: one luma word in each bar and one chroma word in every other bar
		for (int k = 0; k < 8; k++)
			push_word('0, CW'(k * 240), 1'b0);
		for (int k = 0; k < 8; k += 2)
			push_word('0, CW'(k * 120 + 60), 1'b1);
		// field extremes and the 32-bit wrap of the scroll
		push_word('1, '1, 1'b1);
		push_word('1, '0, 1'b0);
		push_word('0, '1, 1'b0);
		push_word(32'h4000_0000, 12'd5, 1'b0);
		push_word(32'h3FFF_FFFF, 12'd2047, 1'b1);

		// width settings: saturating, minimum, maximum, and ordinary
		foreach (WIDTH_PLAN[i]) begin
			write_width(WIDTH_PLAN[i]);
			random_words(PHASE_WORDS);
		end
		repeat (2) begin
			write_width(GW'($urandom_range(8191)));
			random_words(PHASE_WORDS);
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && samples_owed == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
